// ===== sv/nntb_pkg.sv =====
// shared widths and the command and status bundles of the tour builder
package nntb_pkg;

    localparam int NODE_W   = 4;
    localparam int CNT_W    = 5;
    localparam int DIST_W   = 24;
    localparam int SUM_W    = 28;
    localparam int TOUR_MAX = 16;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef struct packed {
        logic load;
        logic init_run;
        logic start_tour;
        logic scan_issue;
        logic step;
        logic keep;
        logic emit;
    } nntb_cmd_t;

    typedef struct packed {
        logic run_empty;
        logic tour_done;
        logic j_last;
        logic start_last;
        logic emit_last;
        logic out_free;
    } nntb_sts_t;

endpackage

// ===== sv/nntb_ram.sv =====
// generic single write port, single read port ram with registered read
module nntb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/nntb_ctrl.sv =====
// sequencer for loads, tour scans, best-tour keeping and result emission
module nntb_ctrl
    import nntb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_kind,
    output logic      s_ready,
    input  nntb_sts_t sts,
    output nntb_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_DRAIN,
        ST_STEP,
        ST_KEEP,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_kind == KIND_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.init_run = 1'b1;
                        if (!sts.run_empty) begin
                            state_next = ST_START;
                        end
                    end
                end
            end
            ST_START: begin
                cmd.start_tour = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.tour_done) begin
                    state_next = ST_KEEP;
                end else begin
                    cmd.scan_issue = 1'b1;
                    if (sts.j_last) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd.step   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_KEEP: begin
                cmd.keep   = 1'b1;
                state_next = sts.start_last ? ST_EMIT : ST_START;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/nntb_dpath.sv =====
// distance store, scan counters, tour registers and output register
module nntb_dpath
    import nntb_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    input  logic [NODE_W-1:0] s_from_node,
    input  logic [NODE_W-1:0] s_to_node,
    input  logic [DIST_W-1:0] s_distance,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [NODE_W-1:0] m_tour_node,
    output logic [SUM_W-1:0]  m_tour_length,
    output logic              m_last,
    input  nntb_cmd_t         cmd,
    output nntb_sts_t         sts
);

    localparam int DEPTH      = MAX_NODES * MAX_NODES;
    localparam int AW         = $clog2(DEPTH);
    localparam int NODE_LIMIT = (MAX_NODES < TOUR_MAX) ? MAX_NODES : TOUR_MAX;

    logic [CNT_W-1:0]  node_count_reg;
    logic [CNT_W-1:0]  n_eff;
    logic [CNT_W-1:0]  n_minus1;

    logic [CNT_W-1:0]  s_reg, pos_reg, j_reg, k_reg;
    logic [NODE_W-1:0] here_reg;
    logic [TOUR_MAX-1:0] visited_reg;
    logic [SUM_W-1:0]  sum_reg, best_sum_reg;
    logic [NODE_W-1:0] pick_reg;
    logic [DIST_W-1:0] pick_w_reg;
    logic              found_reg;
    logic              rd_v_reg;
    logic [NODE_W-1:0] rd_j_reg;
    logic [NODE_W-1:0] cur_tour_reg  [TOUR_MAX];
    logic [NODE_W-1:0] best_tour_reg [TOUR_MAX];

    logic              m_valid_reg;
    logic [NODE_W-1:0] m_node_reg;
    logic [SUM_W-1:0]  m_len_reg;
    logic              m_last_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DIST_W-1:0] ram_rdata;
    logic              better;

    // effective node count, saturated
    assign n_eff    = (32'(node_count_reg) > NODE_LIMIT) ? CNT_W'(NODE_LIMIT) : node_count_reg;
    assign n_minus1 = n_eff - CNT_W'(1);

    assign ram_we    = cmd.load && (32'(s_from_node) < MAX_NODES) && (32'(s_to_node) < MAX_NODES);
    assign ram_waddr = AW'(32'(s_from_node) * MAX_NODES + 32'(s_to_node));
    assign ram_raddr = AW'(32'(here_reg) * MAX_NODES + 32'(j_reg[NODE_W-1:0]));

    nntb_ram #(
        .WIDTH (DIST_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_distance),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign better = (s_reg == '0) || (sum_reg < best_sum_reg);

    assign sts.run_empty  = (n_eff == '0);
    assign sts.tour_done  = (pos_reg >= n_eff);
    assign sts.j_last     = (j_reg == n_minus1);
    assign sts.start_last = (s_reg == n_minus1);
    assign sts.emit_last  = (k_reg == n_minus1);
    assign sts.out_free   = !m_valid_reg || m_ready;

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= CNT_W'(2);
            rd_v_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
            rd_v_reg <= cmd.scan_issue && !visited_reg[j_reg[NODE_W-1:0]];
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // scan, best-tour and output datapath
    always_ff @(posedge aclk) begin
        if (cmd.init_run) begin
            s_reg <= '0;
            k_reg <= '0;
        end
        if (cmd.start_tour) begin
            visited_reg     <= TOUR_MAX'(1) << s_reg[NODE_W-1:0];
            cur_tour_reg[0] <= s_reg[NODE_W-1:0];
            sum_reg         <= '0;
            here_reg        <= s_reg[NODE_W-1:0];
            pos_reg         <= CNT_W'(1);
            j_reg           <= '0;
            found_reg       <= 1'b0;
        end
        if (cmd.scan_issue) begin
            rd_j_reg <= j_reg[NODE_W-1:0];
            j_reg    <= j_reg + CNT_W'(1);
        end
        if (rd_v_reg && (!found_reg || ram_rdata < pick_w_reg)) begin
            found_reg  <= 1'b1;
            pick_reg   <= rd_j_reg;
            pick_w_reg <= ram_rdata;
        end
        if (cmd.step) begin
            visited_reg <= visited_reg | (TOUR_MAX'(1) << pick_reg);
            cur_tour_reg[pos_reg[NODE_W-1:0]] <= pick_reg;
            sum_reg     <= sum_reg + SUM_W'(pick_w_reg);
            here_reg    <= pick_reg;
            pos_reg     <= pos_reg + CNT_W'(1);
            j_reg       <= '0;
            found_reg   <= 1'b0;
        end
        if (cmd.keep) begin
            if (better) begin
                best_sum_reg  <= sum_reg;
                best_tour_reg <= cur_tour_reg;
            end
            s_reg <= s_reg + CNT_W'(1);
        end
        if (cmd.emit) begin
            m_node_reg <= best_tour_reg[k_reg[NODE_W-1:0]];
            m_len_reg  <= best_sum_reg;
            m_last_reg <= (k_reg == n_minus1);
            k_reg      <= k_reg + CNT_W'(1);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_tour_node   = m_node_reg;
    assign m_tour_length = m_len_reg;
    assign m_last        = m_last_reg;

endmodule

// ===== sv/nearest_neighbor_tour_builder_core.sv =====
// top level of the repeated nearest-neighbour tour builder
// a load transfer is taken while idle and loads may follow back to back
// a run over n nodes scans through the single read port of the distance store
// (one entry per cycle), then gives n result transfers at one per cycle while
// the output side is ready
// reset (aresetn low, synchronous) clears the sequencer, flags and node_count to 2;
// the distance store is not cleared and must be written before it is read
module nearest_neighbor_tour_builder_core
    import nntb_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    // node count register
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [NODE_W-1:0] s_from_node,
    input  logic [NODE_W-1:0] s_to_node,
    input  logic [DIST_W-1:0] s_distance,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [NODE_W-1:0] m_tour_node,
    output logic [SUM_W-1:0]  m_tour_length,
    output logic              m_last
);

    // command and status bundles between sequencer and datapath
    nntb_cmd_t cmd;
    nntb_sts_t sts;

    // sequencer: takes transfers only while idle, walks every start node,
    // each position scanning all candidates through the store read port
    nntb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: distance store, minimum search, best tour and output register
    nntb_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_from_node   (s_from_node),
        .s_to_node     (s_to_node),
        .s_distance    (s_distance),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_tour_node   (m_tour_node),
        .m_tour_length (m_tour_length),
        .m_last        (m_last),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule
